>>> hdl/udprx_pkg.sv
package udprx_pkg;

	// Defaults and fixed widths
	localparam int NUM_PORT_SLOTS_DEF = 4;
	localparam int SLOT_W             = 2;
	localparam int CFG_IDX_W          = 3;
	localparam int CNT_W              = 17;

	localparam logic [15:0] UDP_PROTO_NUM = 16'd17;
	localparam logic [CNT_W-1:0] HDR_LEN  = 17'd8;

	// Verdict codes
	localparam logic [2:0] VERDICT_DELIVER   = 3'd0;
	localparam logic [2:0] VERDICT_NO_PORT   = 3'd1;
	localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd2;
	localparam logic [2:0] VERDICT_TOO_SHORT = 3'd3;
	localparam logic [2:0] VERDICT_TOO_LONG  = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_SLOT0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_MASK  = 3'd5;

	// Header byte positions
	localparam logic [CNT_W-1:0] IDX_SPORT_HI = 17'd0;
	localparam logic [CNT_W-1:0] IDX_SPORT_LO = 17'd1;
	localparam logic [CNT_W-1:0] IDX_DPORT_HI = 17'd2;
	localparam logic [CNT_W-1:0] IDX_DPORT_LO = 17'd3;
	localparam logic [CNT_W-1:0] IDX_CSUM_HI  = 17'd6;
	localparam logic [CNT_W-1:0] IDX_CSUM_LO  = 17'd7;

	// Per-datagram record handed from the accumulator to the verdict stage
	typedef struct packed {
		logic [15:0] acc;       // folded sum over the datagram bytes
		logic [18:0] pseudo;    // raw sum of the pseudo-header words
		logic [15:0] n_lo;      // byte count, low 16 bits
		logic        short_dg;  // fewer than 8 bytes
		logic        long_dg;   // more than 65535 bytes
		logic [15:0] csum;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] peer;
	} fin_t;

	// Ones' complement add with end-around carry
	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

>>> hdl/udp_rx_checksum_port_demux.sv
// UDP receive checksum check and port demultiplexer.
// Throughput: one datagram byte per cycle, less while m_tready back-pressure stalls.
// After its last byte, a datagram passes the input register, the datagram record register
// and the result register before its verdict is valid; m_tready low stalls it.
// Reset: arst_n clears the configuration registers, the datagram state and all valid flags;
// the block takes items in the first cycle after reset.
module udp_rx_checksum_port_demux #(
	parameter int NUM_PORT_SLOTS = udprx_pkg::NUM_PORT_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,   // data_byte[7:0], sender_ip[39:8]
	input  logic                              s_tlast,   // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [87:0]                       m_tdata,   // handler_slot[1:0], source_port[17:2],
	                                                     // dest_port[33:18], payload_length[49:34],
	                                                     // peer_ip[81:50], zero[87:82]
	output logic [2:0]                        m_tuser,   // verdict
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [udprx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [31:0]               local_ip_q;
	logic [15:0]               port_slot_q [NUM_PORT_SLOTS];
	logic [NUM_PORT_SLOTS-1:0] slot_open_q;

	logic                      fin_valid;
	logic                      fin_ready;
	udprx_pkg::fin_t           fin;

	logic [2:0]                verdict;
	logic [udprx_pkg::SLOT_W-1:0] handler_slot;
	logic [15:0]               source_port;
	logic [15:0]               dest_port;
	logic [15:0]               payload_length;
	logic [31:0]               peer_ip;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			slot_open_q <= '0;
			for (int k = 0; k < NUM_PORT_SLOTS; k++) begin
				port_slot_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == udprx_pkg::REG_LOCAL_IP) local_ip_q <= cfg_data;
			if (cfg_index == udprx_pkg::REG_SLOT_MASK) begin
				slot_open_q <= cfg_data[NUM_PORT_SLOTS-1:0];
			end
			for (int k = 0; k < NUM_PORT_SLOTS; k++) begin
				if (cfg_index == udprx_pkg::REG_PORT_SLOT0 + udprx_pkg::CFG_IDX_W'(k)) begin
					port_slot_q[k] <= cfg_data[15:0];
				end
			end
		end
	end

	udprx_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata[7:0]),
		.in_sip    (s_tdata[39:8]),
		.in_last   (s_tlast),
		.local_ip  (local_ip_q),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	udprx_verdict #(
		.NUM_PORT_SLOTS (NUM_PORT_SLOTS)
	) u_verdict (
		.clk            (clk),
		.arst_n         (arst_n),
		.fin_valid      (fin_valid),
		.fin_ready      (fin_ready),
		.fin            (fin),
		.port_slot      (port_slot_q),
		.slot_open      (slot_open_q),
		.res_valid      (m_tvalid),
		.res_ready      (m_tready),
		.verdict        (verdict),
		.handler_slot   (handler_slot),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_length (payload_length),
		.peer_ip        (peer_ip)
	);

	// Pack the result item
	assign m_tuser = verdict;
	assign m_tdata = {6'd0, peer_ip, payload_length, dest_port, source_port, handler_slot};

endmodule

>>> hdl/udprx_accum.sv
module udprx_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic [31:0]           in_sip,
	input  logic                  in_last,
	input  logic [31:0]           local_ip,
	output logic                  fin_valid,
	input  logic                  fin_ready,
	output udprx_pkg::fin_t       fin
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [31:0] sip_s1;
	logic        last_s1;

	logic [16:0] cnt_q;
	logic [15:0] acc_q;
	logic [7:0]  held_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] csum_q;
	logic [31:0] sip_q;

	logic [16:0] cnt_n;
	logic [15:0] acc_n;
	logic [7:0]  held_n;
	logic [15:0] sport_n;
	logic [15:0] dport_n;
	logic [15:0] csum_n;
	logic [31:0] sip_n;
	logic [16:0] n_tot;
	logic [7:0]  eff;
	logic        live;
	logic        adv;
	logic        fin_v_s2;
	udprx_pkg::fin_t fin_s2;
	udprx_pkg::fin_t fin_n;

	assign adv       = v_s1 && (!last_s1 || !fin_v_s2 || fin_ready);
	assign in_ready  = !v_s1 || adv;
	assign fin_valid = fin_v_s2;
	assign fin       = fin_s2;

	// Next per-datagram state for the byte in the input register
	always_comb begin
		live    = !cnt_q[16];
		cnt_n   = cnt_q;
		acc_n   = acc_q;
		held_n  = held_q;
		sport_n = sport_q;
		dport_n = dport_q;
		csum_n  = csum_q;
		sip_n   = (cnt_q == udprx_pkg::IDX_SPORT_HI) ? sip_s1 : sip_q;
		eff     = byte_s1;
		if (live) begin
			if (cnt_q == udprx_pkg::IDX_SPORT_HI) sport_n[15:8] = byte_s1;
			if (cnt_q == udprx_pkg::IDX_SPORT_LO) sport_n[7:0]  = byte_s1;
			if (cnt_q == udprx_pkg::IDX_DPORT_HI) dport_n[15:8] = byte_s1;
			if (cnt_q == udprx_pkg::IDX_DPORT_LO) dport_n[7:0]  = byte_s1;
			if (cnt_q == udprx_pkg::IDX_CSUM_HI) begin
				csum_n[15:8] = byte_s1;
				eff          = 8'd0;
			end
			if (cnt_q == udprx_pkg::IDX_CSUM_LO) begin
				csum_n[7:0] = byte_s1;
				eff         = 8'd0;
			end
			if (!cnt_q[0]) begin
				held_n = eff;
				if (last_s1) acc_n = udprx_pkg::fold_add(acc_q, {eff, 8'd0});
			end else begin
				acc_n = udprx_pkg::fold_add(acc_q, {held_q, eff});
			end
			cnt_n = cnt_q + 17'd1;
		end
		n_tot = live ? cnt_q + 17'd1 : 17'h10001;

		fin_n.acc      = acc_n;
		fin_n.pseudo   = {3'd0, sip_n[31:16]} + {3'd0, sip_n[15:0]}
		               + {3'd0, local_ip[31:16]} + {3'd0, local_ip[15:0]}
		               + {3'd0, udprx_pkg::UDP_PROTO_NUM};
		fin_n.n_lo     = n_tot[15:0];
		fin_n.short_dg = n_tot < udprx_pkg::HDR_LEN;
		fin_n.long_dg  = n_tot[16];
		fin_n.csum     = csum_n;
		fin_n.sport    = sport_n;
		fin_n.dport    = dport_n;
		fin_n.peer     = sip_n;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			sip_s1  <= in_sip;
			last_s1 <= in_last;
		end
	end

	// Advance datagram state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			acc_q   <= '0;
			held_q  <= '0;
			sport_q <= '0;
			dport_q <= '0;
			csum_q  <= '0;
			sip_q   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q   <= '0;
				acc_q   <= '0;
				held_q  <= '0;
				sport_q <= '0;
				dport_q <= '0;
				csum_q  <= '0;
				sip_q   <= '0;
			end else begin
				cnt_q   <= cnt_n;
				acc_q   <= acc_n;
				held_q  <= held_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
				csum_q  <= csum_n;
				sip_q   <= sip_n;
			end
		end
	end

	// Hold the finished datagram record for the verdict stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s2 <= 1'b0;
		end else if (adv && last_s1) begin
			fin_v_s2 <= 1'b1;
		end else if (fin_ready) begin
			fin_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			fin_s2 <= fin_n;
		end
	end

endmodule

>>> hdl/udprx_verdict.sv
module udprx_verdict #(
	parameter int NUM_PORT_SLOTS = udprx_pkg::NUM_PORT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fin_valid,
	output logic                          fin_ready,
	input  udprx_pkg::fin_t               fin,
	input  logic [15:0]                   port_slot [NUM_PORT_SLOTS],
	input  logic [NUM_PORT_SLOTS-1:0]     slot_open,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [2:0]                    verdict,
	output logic [udprx_pkg::SLOT_W-1:0]  handler_slot,
	output logic [15:0]                   source_port,
	output logic [15:0]                   dest_port,
	output logic [15:0]                   payload_length,
	output logic [31:0]                   peer_ip
);

	logic [19:0] total;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic        hit;
	logic [udprx_pkg::SLOT_W-1:0] hit_slot;
	logic [2:0]  verdict_n;
	logic [udprx_pkg::SLOT_W-1:0] slot_n;
	logic [15:0] plen_n;
	logic        res_v_q;

	assign fin_ready = !res_v_q || res_ready;
	assign res_valid = res_v_q;

	// Close the ones' complement sum with pseudo-header and length
	always_comb begin
		total = {4'd0, fin.acc} + {1'b0, fin.pseudo} + {4'd0, fin.n_lo};
		fold1 = {1'b0, total[15:0]} + {13'd0, total[19:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
	end

	// Find the lowest open slot that matches the destination port
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = NUM_PORT_SLOTS - 1; i >= 0; i--) begin
			if (slot_open[i] && port_slot[i] == fin.dport) begin
				hit      = 1'b1;
				hit_slot = udprx_pkg::SLOT_W'(i);
			end
		end
	end

	// Pick the verdict by priority
	always_comb begin
		slot_n = '0;
		plen_n = '0;
		priority if (fin.short_dg) begin
			verdict_n = udprx_pkg::VERDICT_TOO_SHORT;
		end else if (fin.long_dg) begin
			verdict_n = udprx_pkg::VERDICT_TOO_LONG;
		end else begin
			plen_n = fin.n_lo - 16'd8;
			if (~fold2 != fin.csum) begin
				verdict_n = udprx_pkg::VERDICT_BAD_CSUM;
			end else if (hit) begin
				verdict_n = udprx_pkg::VERDICT_DELIVER;
				slot_n    = hit_slot;
			end else begin
				verdict_n = udprx_pkg::VERDICT_NO_PORT;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (fin_ready) begin
			res_v_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			verdict        <= verdict_n;
			handler_slot   <= slot_n;
			source_port    <= fin.sport;
			dest_port      <= fin.dport;
			payload_length <= plen_n;
			peer_ip        <= fin.peer;
		end
	end

endmodule
